FILE: rtl/core/bfgr_pkg.sv
package bfgr_pkg;

    // store address wide enough for glyph base plus row offset
    localparam int ADDR_W = 14;

    // request queue between classifier and renderer
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // configuration register indexes (byte address / 4)
    localparam logic [2:0] CFG_FIRST_CODE   = 3'd0;
    localparam logic [2:0] CFG_GLYPH_COUNT  = 3'd1;
    localparam logic [2:0] CFG_GLYPH_HEIGHT = 3'd2;
    localparam logic [2:0] CFG_WIDE_FONT    = 3'd3;
    localparam logic [2:0] CFG_CHAR_SPACING = 3'd4;

    // result status codes
    localparam logic [1:0] STATUS_ROW  = 2'd0;
    localparam logic [1:0] STATUS_BAD  = 2'd1;
    localparam logic [1:0] STATUS_SKIP = 2'd2;
    localparam logic [1:0] STATUS_LOAD = 2'd3;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_DRAW = 2'd1,
        KIND_BAD  = 2'd2,
        KIND_SKIP = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] first_code;
        logic [8:0] glyph_count;
        logic [4:0] glyph_height;
        logic       wide_font;
        logic [7:0] char_spacing;
    } cfg_t;

    // one classified request
    typedef struct packed {
        kind_t              kind;
        logic               new_string;
        logic [15:0]        start_x;
        logic [15:0]        start_y;
        logic [31:0]        color;
        logic [ADDR_W-1:0]  addr;
        logic [15:0]        word;
    } entry_t;

endpackage

FILE: rtl/core/bfgr_cmd_if.sv
interface bfgr_cmd_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [12:0]        font_addr;
    logic [15:0]        font_word;
    logic [7:0]         char_code;
    logic               new_string;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic [31:0]        color;

    modport source (
        output valid, operation, font_addr, font_word, char_code,
               new_string, start_x, start_y, color,
        input  ready
    );

    modport sink (
        input  valid, operation, font_addr, font_word, char_code,
               new_string, start_x, start_y, color,
        output ready
    );
endinterface

FILE: rtl/core/bfgr_rsp_if.sv
interface bfgr_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic [15:0]        row_mask;
    logic [4:0]         glyph_width;
    logic [31:0]        pixel_color;
    logic signed [15:0] next_x;
    logic               last;

    modport source (
        output valid, status, pixel_x, pixel_y, row_mask, glyph_width,
               pixel_color, next_x, last,
        input  ready
    );

    modport sink (
        input  valid, status, pixel_x, pixel_y, row_mask, glyph_width,
               pixel_color, next_x, last,
        output ready
    );
endinterface

FILE: rtl/core/bfgr_queue.sv
module bfgr_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  bfgr_pkg::entry_t push_data,
    output logic            full,
    input  logic            pop,
    output bfgr_pkg::entry_t pop_data,
    output logic            empty
);
    import bfgr_pkg::*;

    entry_t               slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W:0]     count_reg, count_next;

    assign full     = (count_reg == (Q_PTR_W + 1)'(Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/core/bfgr_front.sv
module bfgr_front (
    input  logic             clk,
    input  logic             rst_n,
    input  bfgr_pkg::cfg_t   cfg,
    bfgr_cmd_if.sink         cmd,
    output logic             push,
    output bfgr_pkg::entry_t push_data,
    input  logic             full
);
    import bfgr_pkg::*;

    logic       abort_reg, abort_next;
    logic       abort_eff;
    logic       bad_code;
    logic [7:0] code_off;
    logic [5:0] stride;

    assign cmd.ready = !full;
    assign push      = cmd.valid && !full;

    assign code_off  = cmd.char_code - cfg.first_code;
    // below the first code, or at/after first_code + glyph_count
    assign bad_code  = (cmd.char_code < cfg.first_code)
                    || ({1'b0, code_off} >= cfg.glyph_count);
    assign abort_eff = cmd.new_string ? 1'b0 : abort_reg;
    assign stride    = {1'b0, cfg.glyph_height} + 6'd1;

    always_comb
    begin
        push_data            = '0;
        push_data.color      = cmd.color;
        push_data.start_x    = cmd.start_x;
        push_data.start_y    = cmd.start_y;
        abort_next           = abort_reg;
        if (!cmd.operation)
        begin
            push_data.kind = KIND_LOAD;
            push_data.addr = ADDR_W'(cmd.font_addr);
            push_data.word = cmd.font_word;
        end
        else
        begin
            push_data.new_string = cmd.new_string;
            // glyph base: offset times (height + 1) fits 14 bits
            push_data.addr = ADDR_W'({6'd0, code_off} * {8'd0, stride});
            abort_next     = abort_eff;
            if (abort_eff)
            begin
                push_data.kind = KIND_SKIP;
            end
            else if (bad_code)
            begin
                push_data.kind = KIND_BAD;
                abort_next     = 1'b1;
            end
            else
            begin
                push_data.kind = KIND_DRAW;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abort_reg <= 1'b0;
        end
        else if (push)
        begin
            abort_reg <= abort_next;
        end
    end

endmodule

FILE: rtl/core/bfgr_back.sv
module bfgr_back #(
    parameter int FONT_WORDS = 8192,
    parameter int MAX_ROWS   = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  bfgr_pkg::cfg_t   cfg,
    input  bfgr_pkg::entry_t entry,
    input  logic             q_empty,
    output logic             pop,
    bfgr_rsp_if.source       result
);
    import bfgr_pkg::*;

    localparam int AW      = $clog2(FONT_WORDS);
    localparam int ROW_CAP = (MAX_ROWS < 16) ? MAX_ROWS : 16;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_WIDTH = 3'b010,
        ST_ROW   = 3'b100
    } state_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
        logic [15:0] row_mask;
        logic [4:0]  glyph_width;
        logic [31:0] pixel_color;
        logic [15:0] next_x;
        logic        last;
    } res_t;

    logic [15:0]        font_mem [FONT_WORDS];
    logic [15:0]        rd_data_reg;
    logic               wr_en, rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [AW-1:0]      rd_idx, wr_idx;

    state_t             state_reg, state_next;
    logic [15:0]        cur_x_reg, cur_x_next;
    logic [15:0]        cur_y_reg, cur_y_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [3:0]         row_reg, row_next;
    logic [4:0]         rows_reg, rows_next;
    logic [4:0]         width_reg, width_next;
    logic [15:0]        nx_reg, nx_next;
    logic [31:0]        color_reg, color_next;

    logic               out_valid_reg;
    res_t               out_reg;
    res_t               res;
    logic               emit;
    logic               out_ok;

    logic [15:0]        cx_eff, cy_eff;
    logic [15:0]        raw_w;
    logic [4:0]         w_sat;
    logic [15:0]        nx_calc;
    logic [4:0]         rows_cap;
    logic [15:0]        mask_calc;
    logic               row_last;

    assign out_ok = !out_valid_reg || result.ready;
    assign rd_idx = AW'(rd_addr);
    assign wr_idx = AW'(entry.addr);

    assign cx_eff = entry.new_string ? entry.start_x : cur_x_reg;
    assign cy_eff = entry.new_string ? entry.start_y : cur_y_reg;

    // width word, low byte only for narrow fonts, saturated to font width
    assign raw_w    = cfg.wide_font ? rd_data_reg : {8'd0, rd_data_reg[7:0]};
    assign w_sat    = cfg.wide_font ? ((raw_w > 16'd16) ? 5'd16 : raw_w[4:0])
                                    : ((raw_w > 16'd8)  ? 5'd8  : raw_w[4:0]);
    assign nx_calc  = cur_x_reg + 16'(w_sat) + 16'(cfg.char_spacing);
    assign rows_cap = (cfg.glyph_height > 5'(ROW_CAP)) ? 5'(ROW_CAP) : cfg.glyph_height;
    assign row_last = ({1'b0, row_reg} + 5'd1) == rows_reg;

    // msb-first columns, cut at glyph width
    always_comb
    begin
        for (int n = 0; n < 16; n++)
        begin
            if (cfg.wide_font)
            begin
                mask_calc[n] = rd_data_reg[15 - n] && (5'(n) < width_reg);
            end
            else if (n < 8)
            begin
                mask_calc[n] = rd_data_reg[7 - n] && (5'(n) < width_reg);
            end
            else
            begin
                mask_calc[n] = 1'b0;
            end
        end
    end

    always_comb
    begin
        pop        = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = addr_reg;
        emit       = 1'b0;
        res        = '0;
        state_next = state_reg;
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        addr_next  = addr_reg;
        row_next   = row_reg;
        rows_next  = rows_reg;
        width_next = width_reg;
        nx_next    = nx_reg;
        color_next = color_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty && out_ok)
                begin
                    pop        = 1'b1;
                    cur_x_next = cx_eff;
                    cur_y_next = cy_eff;
                    case (entry.kind) inside
                        KIND_LOAD:
                        begin
                            wr_en      = 1'b1;
                            emit       = 1'b1;
                            res.status = STATUS_LOAD;
                            res.last   = 1'b1;
                        end
                        KIND_BAD, KIND_SKIP:
                        begin
                            emit        = 1'b1;
                            res.status  = (entry.kind == KIND_BAD) ? STATUS_BAD : STATUS_SKIP;
                            res.pixel_x = cx_eff;
                            res.pixel_y = cy_eff;
                            res.next_x  = cx_eff;
                            res.last    = 1'b1;
                        end
                        KIND_DRAW:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = entry.addr;
                            addr_next  = entry.addr + 1'b1;
                            color_next = entry.color;
                            state_next = ST_WIDTH;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_WIDTH:
            begin
                width_next = w_sat;
                nx_next    = nx_calc;
                if (rows_cap == 5'd0)
                begin
                    if (out_ok)
                    begin
                        emit            = 1'b1;
                        res.status      = STATUS_ROW;
                        res.pixel_x     = cur_x_reg;
                        res.pixel_y     = cur_y_reg;
                        res.glyph_width = w_sat;
                        res.pixel_color = color_reg;
                        res.next_x      = nx_calc;
                        res.last        = 1'b1;
                        cur_x_next      = nx_calc;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    addr_next  = addr_reg + 1'b1;
                    row_next   = '0;
                    rows_next  = rows_cap;
                    state_next = ST_ROW;
                end
            end

            ST_ROW:
            begin
                if (out_ok)
                begin
                    emit            = 1'b1;
                    res.status      = STATUS_ROW;
                    res.pixel_x     = cur_x_reg;
                    res.pixel_y     = cur_y_reg + 16'(row_reg);
                    res.row_mask    = mask_calc;
                    res.glyph_width = width_reg;
                    res.pixel_color = color_reg;
                    res.next_x      = nx_reg;
                    res.last        = row_last;
                    if (row_last)
                    begin
                        cur_x_next = nx_reg;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rd_en     = 1'b1;
                        addr_next = addr_reg + 1'b1;
                        row_next  = row_reg + 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            font_mem[wr_idx] <= entry.word;
        end
        if (rd_en)
        begin
            rd_data_reg <= font_mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        row_reg   <= row_next;
        rows_reg  <= rows_next;
        width_reg <= width_next;
        nx_reg    <= nx_next;
        color_reg <= color_next;
        if (emit)
        begin
            out_reg <= res;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.status      = out_reg.status;
    assign result.pixel_x     = out_reg.pixel_x;
    assign result.pixel_y     = out_reg.pixel_y;
    assign result.row_mask    = out_reg.row_mask;
    assign result.glyph_width = out_reg.glyph_width;
    assign result.pixel_color = out_reg.pixel_color;
    assign result.next_x      = out_reg.next_x;
    assign result.last        = out_reg.last;

endmodule

FILE: rtl/core/bitmap_font_glyph_renderer.sv
// channel   dir  handshake      carries
// cmd       in   valid/ready    load word or draw character request
// result    out  valid/ready    one glyph row, or one status per request
// apb       in   psel/penable   font geometry and spacing registers
//
// a draw runs in steps: pop and width read, glyph sizing, then one font
// store read per row; the font store has a single read port. loads, bad
// and skipped characters give their result at the pop. reset clears the
// cursor, the abort flag, the request queue and the result valid flag and
// sets the register defaults; the font store is undefined until loaded.
// the classifier keeps taking requests into a four-entry queue while the
// renderer waits on a stalled result register.
module bitmap_font_glyph_renderer #(
    parameter int FONT_WORDS = 8192,
    parameter int MAX_ROWS   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    bfgr_cmd_if.sink    cmd,
    bfgr_rsp_if.source  result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bfgr_pkg::*;

    cfg_t       cfg_reg;
    logic       cfg_wr;
    logic [2:0] reg_idx;

    entry_t     push_data, pop_data;
    logic       push, pop, q_full, q_empty;

    // apb: no wait states, register index from the word address
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_code   <= 8'd32;
            cfg_reg.glyph_count  <= 9'd96;
            cfg_reg.glyph_height <= 5'd8;
            cfg_reg.wide_font    <= 1'b0;
            cfg_reg.char_spacing <= 8'd1;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                CFG_FIRST_CODE:   cfg_reg.first_code   <= pwdata[7:0];
                CFG_GLYPH_COUNT:  cfg_reg.glyph_count  <= pwdata[8:0];
                CFG_GLYPH_HEIGHT: cfg_reg.glyph_height <= pwdata[4:0];
                CFG_WIDE_FONT:    cfg_reg.wide_font    <= pwdata[0];
                CFG_CHAR_SPACING: cfg_reg.char_spacing <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (reg_idx)
            CFG_FIRST_CODE:   prdata = 32'(cfg_reg.first_code);
            CFG_GLYPH_COUNT:  prdata = 32'(cfg_reg.glyph_count);
            CFG_GLYPH_HEIGHT: prdata = 32'(cfg_reg.glyph_height);
            CFG_WIDE_FONT:    prdata = 32'(cfg_reg.wide_font);
            CFG_CHAR_SPACING: prdata = 32'(cfg_reg.char_spacing);
            default:          prdata = '0;
        endcase
    end

    // classify: load, draw, bad character or skipped after abort
    bfgr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .push      (push),
        .push_data (push_data),
        .full      (q_full)
    );

    // decouples request intake from row rendering
    bfgr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    // font store, cursor and row rendering; result register sits in here
    bfgr_back #(
        .FONT_WORDS (FONT_WORDS),
        .MAX_ROWS   (MAX_ROWS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .entry   (pop_data),
        .q_empty (q_empty),
        .pop     (pop),
        .result  (result)
    );

endmodule
